// ----- rtl/core/rsnh_pkg.sv -----
package rsnh_pkg;

  localparam int unsigned NSEG    = 64;
  localparam int unsigned SEG_W   = $clog2(NSEG);
  localparam int unsigned CNT_W   = SEG_W + 1;
  localparam int unsigned COORD_W = 14;
  localparam int unsigned DIFF_W  = COORD_W + 1;
  localparam int unsigned ENTRY_W = 4 * COORD_W;
  localparam int unsigned DIR_W   = 16;
  localparam int unsigned MAG_W   = DIR_W + 1;
  localparam int unsigned MAXD_W  = 13;
  localparam int unsigned SCNT_W  = 7;
  localparam int unsigned XY_W    = 19;
  localparam int unsigned DIST_W  = 17;
  localparam int unsigned PROD_W  = 32;
  localparam int unsigned NUM_W   = 54;
  localparam int unsigned QUO_W   = 21;
  localparam int unsigned DEN2_W  = PROD_W + 1;
  localparam int unsigned IDX_W   = 4;
  localparam int unsigned CFG_W   = 13;
  localparam int unsigned DRAIN_CYC = 6;
  localparam int unsigned DCNT_W  = 3;
  localparam logic [MAXD_W-1:0] MAXD_RST = MAXD_W'(215);
  localparam logic [MAG_W-1:0]  DIST_MAG = MAG_W'(16384);

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_CAST = 1'b1
  } opcode_e;

  typedef enum logic [IDX_W-1:0] {
    REG_MAX_DIST  = 4'd0,
    REG_SEG_COUNT = 4'd1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DPREP,
    ST_DSTART,
    ST_DWAIT,
    ST_FIN
  } state_e;

  typedef enum logic [1:0] {
    DIV_X,
    DIV_Y,
    DIV_T
  } div_sel_e;

  typedef struct packed {
    logic             cast_load;
    logic             rd_en;
    logic [SEG_W-1:0] rd_addr;
    logic             div_prep;
    logic             div_start;
    div_sel_e         div_sel;
    logic             out_load;
  } cmd_t;

  typedef struct packed {
    logic found;
    logic div_done;
  } sts_t;

endpackage

// ----- rtl/core/rsnh_div.sv -----
module rsnh_div
  import rsnh_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [NUM_W-1:0]  num_i,
  input  logic [DEN2_W-1:0] den2_i,
  output logic              done_o,
  output logic [QUO_W-1:0]  quo_o
);

  logic [DEN2_W-1:0]        rem_q;
  logic [QUO_W-1:0]         low_q;
  logic [$clog2(QUO_W)-1:0] cnt_q;
  logic                     run_q;
  logic                     done_q;
  logic [DEN2_W:0]          trial;
  logic                     ge;

  assign trial = {rem_q, low_q[QUO_W-1]};
  assign ge    = trial >= {1'b0, den2_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == $clog2(QUO_W)'(QUO_W - 1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= num_i[NUM_W-1:QUO_W];
      low_q <= num_i[QUO_W-1:0];
    end else if (run_q) begin
      rem_q <= ge ? DEN2_W'(trial - {1'b0, den2_i}) : DEN2_W'(trial);
      low_q <= {low_q[QUO_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quo_o  = low_q;

endmodule

// ----- rtl/core/rsnh_ctrl.sv -----
module rsnh_ctrl
  import rsnh_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cast_i,
  input  logic [SCNT_W-1:0] seg_count_i,
  input  sts_t              sts_i,
  output cmd_t              cmd_o,
  output logic              busy_o
);

  state_e            state_q, state_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [DCNT_W-1:0] dcnt_q, dcnt_d;
  div_sel_e          sel_q, sel_d;
  logic [CNT_W-1:0]  n_seg;

  assign n_seg = (seg_count_i > SCNT_W'(NSEG)) ? CNT_W'(NSEG) : CNT_W'(seg_count_i);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (cast_i) begin
          state_d = (n_seg == '0) ? ST_DRAIN : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (cnt_q == n_seg - 1'b1) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (dcnt_q == DCNT_W'(DRAIN_CYC - 1)) begin
          state_d = sts_i.found ? ST_DPREP : ST_FIN;
        end
      end
      ST_DPREP:  state_d = ST_DSTART;
      ST_DSTART: state_d = ST_DWAIT;
      ST_DWAIT: begin
        if (sts_i.div_done) begin
          state_d = (sel_q == DIV_T) ? ST_FIN : ST_DPREP;
        end
      end
      ST_FIN:  state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cnt_d  = cnt_q;
    dcnt_d = dcnt_q;
    sel_d  = sel_q;
    case (state_q)
      ST_IDLE: begin
        cnt_d  = '0;
        dcnt_d = '0;
        sel_d  = DIV_X;
      end
      ST_SCAN:  cnt_d = cnt_q + 1'b1;
      ST_DRAIN: dcnt_d = dcnt_q + 1'b1;
      ST_DWAIT: begin
        if (sts_i.div_done) begin
          case (sel_q)
            DIV_X:   sel_d = DIV_Y;
            DIV_Y:   sel_d = DIV_T;
            default: sel_d = DIV_T;
          endcase
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    cmd_o.cast_load = (state_q == ST_IDLE) && cast_i;
    cmd_o.rd_en     = state_q == ST_SCAN;
    cmd_o.rd_addr   = cnt_q[SEG_W-1:0];
    cmd_o.div_prep  = state_q == ST_DPREP;
    cmd_o.div_start = state_q == ST_DSTART;
    cmd_o.div_sel   = sel_q;
    cmd_o.out_load  = state_q == ST_FIN;
    busy_o          = state_q != ST_IDLE;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      dcnt_q  <= '0;
      sel_q   <= DIV_X;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      dcnt_q  <= dcnt_d;
      sel_q   <= sel_d;
    end
  end

endmodule

// ----- rtl/core/rsnh_dp.sv -----
module rsnh_dp
  import rsnh_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  cmd_t                     cmd_i,
  output sts_t                     sts_o,
  input  logic                     mem_we_i,
  input  logic [SEG_W-1:0]         seg_index_i,
  input  logic signed [COORD_W-1:0] start_x_i,
  input  logic signed [COORD_W-1:0] start_y_i,
  input  logic signed [COORD_W-1:0] end_x_i,
  input  logic signed [COORD_W-1:0] end_y_i,
  input  logic signed [COORD_W-1:0] origin_x_i,
  input  logic signed [COORD_W-1:0] origin_y_i,
  input  logic signed [DIR_W-1:0]  dir_x_i,
  input  logic signed [DIR_W-1:0]  dir_y_i,
  input  logic [MAXD_W-1:0]        max_dist_i,
  output logic                     wall_hit_o,
  output logic signed [XY_W-1:0]   hit_x_o,
  output logic signed [XY_W-1:0]   hit_y_o,
  output logic [DIST_W-1:0]        hit_dist_o,
  output logic [SEG_W-1:0]         hit_segment_o
);

  logic [ENTRY_W-1:0] mem_q [NSEG];
  logic [ENTRY_W-1:0] rd_q;
  logic               v0_q, v1_q, v2_q, v3_q, v4_q;
  logic [SEG_W-1:0]   i0_q, i1_q, i2_q, i3_q, i4_q;

  logic signed [COORD_W-1:0] ox_q, oy_q;
  logic signed [DIR_W-1:0]   dx_q, dy_q;

  logic signed [COORD_W-1:0] r_sx, r_sy, r_ex, r_ey;
  logic signed [DIFF_W-1:0]  sx1_q, sy1_q, wx1_q, wy1_q;
  logic signed [PROD_W-1:0]  den2_q, nt2_q, nu2_q;
  logic signed [PROD_W-1:0]  den_a, nt_a, nu_a;
  logic                      neg, ok3;
  logic [PROD_W-1:0]         nt3_q, den3_q, nt4_q, den4_q;
  logic [PROD_W+13:0]        rng_l, rng_r;
  logic [2*PROD_W-1:0]       cross_a, cross_b;

  logic              found_q;
  logic [PROD_W-1:0] bnt_q, bden_q;
  logic [SEG_W-1:0]  bidx_q;

  logic [MAG_W-1:0]  dxm, dym, mag;
  logic [NUM_W-1:0]  num_q;
  logic              div_done;
  logic [QUO_W-1:0]  quo;
  logic [QUO_W-1:0]  qx_q, qy_q, qd_q;

  logic [QUO_W-1:0]        mqx, mqy, ux, uy;
  logic signed [QUO_W+1:0] sqx, sqy;
  logic signed [QUO_W+2:0] sumx, sumy;
  logic [DIST_W-1:0]       cap;
  logic [QUO_W-1:0]        dsel;

  function automatic logic signed [XY_W-1:0] sat_xy(input logic signed [QUO_W+2:0] v);
    logic signed [QUO_W+2:0] hi, lo;
    hi = (QUO_W+3)'(2**(XY_W-1) - 1);
    lo = -(QUO_W+3)'(2**(XY_W-1));
    if (v > hi) begin
      return XY_W'(hi);
    end else if (v < lo) begin
      return XY_W'(lo);
    end
    return XY_W'(v);
  endfunction

  always_ff @(posedge clk_i) begin
    if (mem_we_i) begin
      mem_q[seg_index_i] <= {start_x_i, start_y_i, end_x_i, end_y_i};
    end
    if (cmd_i.rd_en) begin
      rd_q <= mem_q[cmd_i.rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cast_load) begin
      ox_q <= origin_x_i;
      oy_q <= origin_y_i;
      dx_q <= dir_x_i;
      dy_q <= dir_y_i;
    end
  end

  assign {r_sx, r_sy, r_ex, r_ey} = rd_q;

  always_comb begin
    neg   = den2_q < 0;
    den_a = neg ? -den2_q : den2_q;
    nt_a  = neg ? -nt2_q : nt2_q;
    nu_a  = neg ? -nu2_q : nu2_q;
    ok3   = (den2_q != 0) && (nt_a >= 0) && (nu_a >= 0) && (nu_a <= den_a);
    rng_l = {nt3_q, 14'b0};
    rng_r = (PROD_W+14)'(max_dist_i) * (PROD_W+14)'(den3_q);
    cross_a = (2*PROD_W)'(nt4_q) * (2*PROD_W)'(bden_q);
    cross_b = (2*PROD_W)'(bnt_q) * (2*PROD_W)'(den4_q);
  end

  always_ff @(posedge clk_i) begin
    i0_q  <= cmd_i.rd_addr;
    i1_q  <= i0_q;
    sx1_q <= DIFF_W'(r_ex) - DIFF_W'(r_sx);
    sy1_q <= DIFF_W'(r_ey) - DIFF_W'(r_sy);
    wx1_q <= DIFF_W'(r_sx) - DIFF_W'(ox_q);
    wy1_q <= DIFF_W'(r_sy) - DIFF_W'(oy_q);
    i2_q  <= i1_q;
    den2_q <= PROD_W'(dx_q) * PROD_W'(sy1_q) - PROD_W'(dy_q) * PROD_W'(sx1_q);
    nt2_q  <= PROD_W'(wx1_q) * PROD_W'(sy1_q) - PROD_W'(wy1_q) * PROD_W'(sx1_q);
    nu2_q  <= PROD_W'(wx1_q) * PROD_W'(dy_q) - PROD_W'(wy1_q) * PROD_W'(dx_q);
    i3_q   <= i2_q;
    nt3_q  <= nt_a;
    den3_q <= den_a;
    i4_q   <= i3_q;
    nt4_q  <= nt3_q;
    den4_q <= den3_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q    <= 1'b0;
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
      v4_q    <= 1'b0;
      found_q <= 1'b0;
    end else begin
      v0_q <= cmd_i.rd_en;
      v1_q <= v0_q;
      v2_q <= v1_q;
      v3_q <= v2_q && ok3;
      v4_q <= v3_q && (rng_l <= rng_r);
      if (cmd_i.cast_load) begin
        found_q <= 1'b0;
      end else if (v4_q && (!found_q || (cross_a < cross_b))) begin
        found_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (v4_q && (!found_q || (cross_a < cross_b))) begin
      bnt_q  <= nt4_q;
      bden_q <= den4_q;
      bidx_q <= i4_q;
    end
  end

  assign dxm = dx_q[DIR_W-1] ? MAG_W'(-MAG_W'(dx_q)) : MAG_W'(dx_q);
  assign dym = dy_q[DIR_W-1] ? MAG_W'(-MAG_W'(dy_q)) : MAG_W'(dy_q);

  always_comb begin
    case (cmd_i.div_sel)
      DIV_X:   mag = dxm;
      DIV_Y:   mag = dym;
      DIV_T:   mag = DIST_MAG;
      default: mag = DIST_MAG;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_prep) begin
      num_q <= ((NUM_W'(bnt_q) * NUM_W'(mag)) << 5) + NUM_W'(bden_q);
    end
    if (div_done) begin
      case (cmd_i.div_sel)
        DIV_X:   qx_q <= quo;
        DIV_Y:   qy_q <= quo;
        DIV_T:   qd_q <= quo;
        default: qd_q <= quo;
      endcase
    end
  end

  rsnh_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (num_q),
    .den2_i  ({bden_q, 1'b0}),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  assign sts_o.found    = found_q;
  assign sts_o.div_done = div_done;

  always_comb begin
    mqx  = QUO_W'((QUO_W+10)'(dxm) * (QUO_W+10)'(max_dist_i) + (QUO_W+10)'(512) >> 10);
    mqy  = QUO_W'((QUO_W+10)'(dym) * (QUO_W+10)'(max_dist_i) + (QUO_W+10)'(512) >> 10);
    ux   = found_q ? qx_q : mqx;
    uy   = found_q ? qy_q : mqy;
    sqx  = dx_q[DIR_W-1] ? -(QUO_W+2)'(ux) : (QUO_W+2)'(ux);
    sqy  = dy_q[DIR_W-1] ? -(QUO_W+2)'(uy) : (QUO_W+2)'(uy);
    sumx = ((QUO_W+3)'(ox_q) <<< 4) + (QUO_W+3)'(sqx);
    sumy = ((QUO_W+3)'(oy_q) <<< 4) + (QUO_W+3)'(sqy);
    cap  = {max_dist_i, 4'b0};
    dsel = found_q ? qd_q : QUO_W'(cap);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      wall_hit_o    <= found_q;
      hit_x_o       <= sat_xy(sumx);
      hit_y_o       <= sat_xy(sumy);
      hit_dist_o    <= (dsel > QUO_W'(cap)) ? cap : DIST_W'(dsel);
      hit_segment_o <= found_q ? bidx_q : '0;
    end
  end

endmodule

// ----- rtl/core/ray_segment_nearest_hit_top.sv -----
// Nearest wall hit of a ray against a table of up to 64 line segments.
// An item is a transaction taken when start_i is high and busy_o is low.
// A load item (opcode_i = 0) writes one segment into slot seg_index_i in
// that cycle and produces no result; it never raises busy_o.
// A cast item (opcode_i = 1) raises busy_o and scans slots 0 to n-1, one
// segment per cycle through a five stage cross product pipeline, where n is
// seg_count capped at 64. A hit is then resolved by three serial divisions in
// a shared radix-2 divider for hit_x, hit_y and hit_dist. The result is shown
// for exactly one cycle with done_o high; the receiver cannot stall, so it
// must sample the result in that cycle. busy_o is low again in the cycle of
// done_o, so a new item may be started then.
// The configuration channel (cfg_valid_i, cfg_ready_o) is always ready. It is
// to be written only while the block is idle; the block does not enforce it.
// Register 0 is max_dist, register 1 is seg_count; other indexes are ignored.
// Reset clears the controller and restores max_dist to 215 and seg_count to
// 0. The segment table is not cleared: only loaded slots may be scanned.
module ray_segment_nearest_hit_top
  import rsnh_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  output logic                      busy_o,
  input  logic                      opcode_i,
  input  logic [SEG_W-1:0]          seg_index_i,
  input  logic signed [COORD_W-1:0] start_x_i,
  input  logic signed [COORD_W-1:0] start_y_i,
  input  logic signed [COORD_W-1:0] end_x_i,
  input  logic signed [COORD_W-1:0] end_y_i,
  input  logic signed [COORD_W-1:0] origin_x_i,
  input  logic signed [COORD_W-1:0] origin_y_i,
  input  logic signed [DIR_W-1:0]   dir_x_i,
  input  logic signed [DIR_W-1:0]   dir_y_i,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [IDX_W-1:0]          cfg_index_i,
  input  logic [CFG_W-1:0]          cfg_data_i,
  output logic                      done_o,
  output logic                      wall_hit_o,
  output logic signed [XY_W-1:0]    hit_x_o,
  output logic signed [XY_W-1:0]    hit_y_o,
  output logic [DIST_W-1:0]         hit_dist_o,
  output logic [SEG_W-1:0]          hit_segment_o
);

  logic [MAXD_W-1:0] max_dist_q;
  logic [SCNT_W-1:0] seg_count_q;
  logic              done_q;
  logic              acc, cast_acc, load_acc;
  cmd_t              cmd;
  sts_t              sts;

  assign acc      = start_i && !busy_o;
  assign cast_acc = acc && (opcode_i == OP_CAST);
  assign load_acc = acc && (opcode_i == OP_LOAD);
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_dist_q  <= MAXD_RST;
      seg_count_q <= '0;
      done_q      <= 1'b0;
    end else begin
      done_q <= cmd.out_load;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          REG_MAX_DIST:  max_dist_q  <= cfg_data_i[MAXD_W-1:0];
          REG_SEG_COUNT: seg_count_q <= cfg_data_i[SCNT_W-1:0];
          default: ;
        endcase
      end
    end
  end

  assign done_o = done_q;

  rsnh_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cast_i      (cast_acc),
    .seg_count_i (seg_count_q),
    .sts_i       (sts),
    .cmd_o       (cmd),
    .busy_o      (busy_o)
  );

  rsnh_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .mem_we_i      (load_acc),
    .seg_index_i   (seg_index_i),
    .start_x_i     (start_x_i),
    .start_y_i     (start_y_i),
    .end_x_i       (end_x_i),
    .end_y_i       (end_y_i),
    .origin_x_i    (origin_x_i),
    .origin_y_i    (origin_y_i),
    .dir_x_i       (dir_x_i),
    .dir_y_i       (dir_y_i),
    .max_dist_i    (max_dist_q),
    .wall_hit_o    (wall_hit_o),
    .hit_x_o       (hit_x_o),
    .hit_y_o       (hit_y_o),
    .hit_dist_o    (hit_dist_o),
    .hit_segment_o (hit_segment_o)
  );

endmodule

// ----- rtl/core/rsnh_chk.sv -----
module rsnh_chk
  import rsnh_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             start_i,
  input logic             busy_o,
  input logic             opcode_i,
  input logic             done_o,
  input logic             wall_hit_o,
  input logic [SEG_W-1:0] hit_segment_o
);

  a_cast_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && (opcode_i == OP_CAST)) |=> busy_o)
    else $error("cast transaction did not raise busy");

  a_busy_from_cast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy_o) |-> $past(start_i && (opcode_i == OP_CAST)))
    else $error("busy rose without a cast transaction");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (!busy_o && !$past(done_o)))
    else $error("result strobe while busy or repeated");

  a_miss_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !wall_hit_o) |-> (hit_segment_o == '0))
    else $error("miss reported a nonzero segment");

endmodule

bind ray_segment_nearest_hit_top rsnh_chk u_chk (.*);
